@@ hdl/cgl_pkg.sv @@
// Shared types and constants of the color gradient lookup.
// Stop packing, work item layout and register indexes; no dependencies.
package cgl_pkg;

   localparam int VAL_W       = 32;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int STOP_REGS   = 7;
   localparam int MAX_STOPS   = 7;
   localparam int CNT_W       = 3;
   localparam int STOP_W      = VAL_W + NUM_CHAN * CHAN_W;
   localparam int NUM_W       = VAL_W + 1;
   localparam int PROD_W      = NUM_W + CHAN_W;
   localparam int DIFF_W      = CHAN_W + 1;
   localparam int SUM_W       = CHAN_W + 2;
   localparam int DIV_STAGES  = CHAN_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_W       = 32;
   localparam int RSP_W       = NUM_CHAN * CHAN_W;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_BASE  = 3'd1;

   typedef logic [CHAN_W-1:0] chan_type;

   // color[0] red, color[1] green, color[2] blue above the value
   typedef struct packed {
      chan_type [NUM_CHAN-1:0] color;
      logic signed [VAL_W-1:0] value;
   } stop_type;

   typedef struct packed {
      logic                    interp;
      logic signed [VAL_W-1:0] sample;
      stop_type                lo;
      stop_type                hi;
   } work_type;

endpackage

@@ hdl/color_gradient_lookup.sv @@
// Top level of the color gradient lookup: stop registers, front end, queue
// and back end. Depends on cgl_pkg, cgl_front, cgl_queue and cgl_back.
//
// Maps each signed Q16.16 sample to an RGB color from up to seven stops kept
// sorted by value: below the first stop it gives the first stop's color, past
// the last the last stop's, between two stops a per-channel linear blend
// truncated toward zero, and black when fewer than two stops are set. One
// item is taken every clock while nothing stalls. The front end searches all
// stops combinationally, a four-item queue decouples it from the back end,
// whose divider resolves one quotient bit per stage per channel. The user
// must write stops and the stop count through the csr_ port only while no
// item is in flight; the block does not enforce this.
module color_gradient_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [cgl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cgl_pkg::STOP_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cgl_pkg::REQ_W-1:0]         req_tdata,   // sample_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cgl_pkg::RSP_W-1:0]         rsp_tdata    // red, green, blue
);
   import cgl_pkg::*;

   logic [CNT_W-1:0]           stop_count_ff;
   stop_type [STOP_REGS-1:0]   stop_ff;

   logic     front_valid;
   logic     front_ready;
   work_type front_item;
   logic     queue_valid;
   logic     back_ready;
   work_type queue_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         stop_ff       <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_STOP_COUNT) begin
            stop_count_ff <= csr_wdata[CNT_W-1:0];
         end
         for (int j = 0; j < STOP_REGS; j++) begin
            if (csr_index == CSR_STOP_BASE + CSR_IDX_W'(j)) begin
               stop_ff[j] <= csr_wdata;
            end
         end
      end
   end

   cgl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .stop_count (stop_count_ff),
      .stops      (stop_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .work_valid (front_valid),
      .work_ready (front_ready),
      .work_item  (front_item)
   );

   cgl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_item   (queue_item)
   );

   cgl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (back_ready),
      .item       (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a classified item refused by a full queue stays in the front register
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      front_valid && !front_ready |=> front_valid)
      else $error("front item dropped while queue full");

   // a stalled output freezes the back end, so nothing leaves the queue
   a_back_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !(queue_valid && back_ready))
      else $error("queue popped while output stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !front_valid && !queue_valid)
      else $error("pipeline not empty after reset");

endmodule

@@ hdl/cgl_front.sv @@
// Front end of the color gradient lookup: accepts a sample, searches the stops
// and classifies it into a work item. Depends on cgl_pkg.
module cgl_front (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [cgl_pkg::CNT_W-1:0]                   stop_count,
   input  cgl_pkg::stop_type [cgl_pkg::STOP_REGS-1:0]  stops,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [cgl_pkg::REQ_W-1:0]                   req_tdata,   // sample_value
   output logic                                        work_valid,
   input  logic                                        work_ready,
   output cgl_pkg::work_type                           work_item
);
   import cgl_pkg::*;

   logic                 front_valid_ff, front_valid_in;
   work_type             front_item_ff, front_item_in;
   work_type             classified;
   logic [CNT_W-1:0]     n_used;
   logic [STOP_REGS-1:0] first_gt;
   logic [STOP_REGS-1:0] lo_sel;
   logic                 found;
   logic                 accept;

   always_comb begin
      logic gt;
      n_used = (stop_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count;
      found = 1'b0;
      first_gt = '0;
      // first stop strictly above the sample
      for (int j = 0; j < STOP_REGS; j++) begin
         gt = (CNT_W'(j) < n_used) && (stops[j].value > $signed(req_tdata));
         if (gt && !found) begin
            first_gt[j] = 1'b1;
         end
         found = found | gt;
      end

      lo_sel = '0;
      if (n_used < CNT_W'(2)) begin
         lo_sel = '0;
      end else if (!found) begin
         for (int j = 0; j < STOP_REGS; j++) begin
            lo_sel[j] = (CNT_W'(j) == n_used - CNT_W'(1));
         end
      end else if (first_gt[0]) begin
         lo_sel[0] = 1'b1;
      end else begin
         lo_sel[STOP_REGS-2:0] = first_gt[STOP_REGS-1:1];
      end

      classified.interp = (n_used >= CNT_W'(2)) && found && !first_gt[0];
      classified.sample = $signed(req_tdata);
      classified.lo = '0;
      classified.hi = '0;
      for (int j = 0; j < STOP_REGS; j++) begin
         classified.lo = classified.lo | (lo_sel[j] ? stops[j] : '0);
         classified.hi = classified.hi | (first_gt[j] ? stops[j] : '0);
      end
   end

   assign req_tready = !front_valid_ff || work_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_item_in  = front_item_ff;
      if (accept) begin
         front_valid_in = 1'b1;
         front_item_in  = classified;
      end else if (work_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_item_ff <= front_item_in;
   end

   assign work_valid = front_valid_ff;
   assign work_item  = front_item_ff;

endmodule

@@ hdl/cgl_queue.sv @@
// Short queue of classified work items between front and back end.
// Depends on cgl_pkg.
module cgl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cgl_pkg::work_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cgl_pkg::work_type pop_item
);
   import cgl_pkg::*;

   work_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/cgl_back.sv @@
// Back end of the color gradient lookup: interpolation pipeline with a
// per-channel multiplier, a one-bit-per-stage divider and the output register.
// Depends on cgl_pkg.
module cgl_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   output logic                       item_ready,
   input  cgl_pkg::work_type          item,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [cgl_pkg::RSP_W-1:0]  rsp_tdata    // red, green, blue
);
   import cgl_pkg::*;

   logic advance;

   // prep stage
   logic              p_valid_ff;
   logic [NUM_W-1:0]  p_num_ff, p_num_in;
   logic [NUM_W-1:0]  p_den_ff, p_den_in;
   logic [NUM_CHAN-1:0] p_neg_ff, p_neg_in;
   chan_type          p_mag_ff [NUM_CHAN];
   chan_type          p_mag_in [NUM_CHAN];
   chan_type          p_base_ff [NUM_CHAN];

   // divider stages, index 0 holds the product
   logic                d_valid_ff [DIV_STAGES+1];
   logic [PROD_W-1:0]   d_rem_ff   [DIV_STAGES+1][NUM_CHAN];
   logic [PROD_W-1:0]   d_rem_in   [DIV_STAGES+1][NUM_CHAN];
   chan_type            d_quo_ff   [DIV_STAGES+1][NUM_CHAN];
   chan_type            d_quo_in   [DIV_STAGES+1][NUM_CHAN];
   logic [NUM_W-1:0]    d_den_ff   [DIV_STAGES+1];
   logic [NUM_CHAN-1:0] d_neg_ff   [DIV_STAGES+1];
   chan_type            d_base_ff  [DIV_STAGES+1][NUM_CHAN];

   logic                    out_valid_ff;
   logic [RSP_W-1:0]        out_data_ff, out_data_in;

   // the whole pipe moves as one unless a result waits at the output
   assign advance    = !out_valid_ff || rsp_tready;
   assign item_ready = advance;

   always_comb begin
      logic [DIFF_W-1:0] diff;
      if (item.interp) begin
         p_num_in = {item.sample[VAL_W-1], item.sample}
                  - {item.lo.value[VAL_W-1], item.lo.value};
         p_den_in = {item.hi.value[VAL_W-1], item.hi.value}
                  - {item.lo.value[VAL_W-1], item.lo.value};
      end else begin
         p_num_in = '0;
         p_den_in = NUM_W'(1);
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         diff = {1'b0, item.hi.color[c]} - {1'b0, item.lo.color[c]};
         p_neg_in[c] = diff[DIFF_W-1];
         p_mag_in[c] = diff[DIFF_W-1] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
      end
   end

   // restoring division, one quotient bit per stage, MSB first
   always_comb begin
      logic [PROD_W-1:0] trial;
      logic              hit;
      for (int c = 0; c < NUM_CHAN; c++) begin
         d_rem_in[0][c] = PROD_W'(p_num_ff) * PROD_W'(p_mag_ff[c]);
         d_quo_in[0][c] = '0;
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            trial = PROD_W'(d_den_ff[s]) << (DIV_STAGES - 1 - s);
            hit   = (d_rem_ff[s][c] >= trial);
            d_rem_in[s+1][c] = hit ? d_rem_ff[s][c] - trial : d_rem_ff[s][c];
            d_quo_in[s+1][c] = {d_quo_ff[s][c][CHAN_W-2:0], hit};
         end
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] delta;
      logic signed [SUM_W-1:0] sum;
      for (int c = 0; c < NUM_CHAN; c++) begin
         delta = $signed({2'b00, d_quo_ff[DIV_STAGES][c]});
         if (d_neg_ff[DIV_STAGES][c]) begin
            delta = -delta;
         end
         sum = $signed({2'b00, d_base_ff[DIV_STAGES][c]}) + delta;
         if (sum < 0) begin
            out_data_in[c*CHAN_W +: CHAN_W] = '0;
         end else if (sum > $signed(SUM_W'({CHAN_W{1'b1}}))) begin
            out_data_in[c*CHAN_W +: CHAN_W] = '1;
         end else begin
            out_data_in[c*CHAN_W +: CHAN_W] = sum[CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s <= DIV_STAGES; s++) begin
            d_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         p_valid_ff    <= item_valid;
         d_valid_ff[0] <= p_valid_ff;
         for (int s = 0; s < DIV_STAGES; s++) begin
            d_valid_ff[s+1] <= d_valid_ff[s];
         end
         out_valid_ff <= d_valid_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_num_ff <= p_num_in;
         p_den_ff <= p_den_in;
         p_neg_ff <= p_neg_in;
         for (int c = 0; c < NUM_CHAN; c++) begin
            p_mag_ff[c]  <= p_mag_in[c];
            p_base_ff[c] <= item.lo.color[c];
         end
         d_den_ff[0] <= p_den_ff;
         d_neg_ff[0] <= p_neg_ff;
         for (int c = 0; c < NUM_CHAN; c++) begin
            d_rem_ff[0][c]  <= d_rem_in[0][c];
            d_quo_ff[0][c]  <= d_quo_in[0][c];
            d_base_ff[0][c] <= p_base_ff[c];
         end
         for (int s = 0; s < DIV_STAGES; s++) begin
            d_den_ff[s+1] <= d_den_ff[s];
            d_neg_ff[s+1] <= d_neg_ff[s];
            for (int c = 0; c < NUM_CHAN; c++) begin
               d_rem_ff[s+1][c]  <= d_rem_in[s+1][c];
               d_quo_ff[s+1][c]  <= d_quo_in[s+1][c];
               d_base_ff[s+1][c] <= d_base_ff[s][c];
            end
         end
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
